[design/sse_pkg.sv]
package sse_pkg;

  localparam int NUM_SETS_DEF     = 16;
  localparam int SEMS_PER_SET_DEF = 16;
  localparam int MAX_RESULTS      = 16;
  localparam int IDENT_W          = 31;

  typedef enum logic [2:0] {
    ACT_GET        = 3'd0,
    ACT_OPERATE    = 3'd1,
    ACT_REMOVE     = 3'd2,
    ACT_READ_VAL   = 3'd3,
    ACT_WRITE_VAL  = 3'd4,
    ACT_READ_OWNER = 3'd5,
    ACT_READ_ALL   = 3'd6,
    ACT_STAT       = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ERROR   = 2'd1,
    ST_BLOCKED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    RES_ERROR,
    RES_GET,
    RES_REMOVE,
    RES_STAT,
    RES_OP,
    RES_ALL
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_CREATE,
    S_CLEAR,
    S_GET,
    S_ERROR,
    S_REMOVE,
    S_STAT,
    S_SEM_RD,
    S_SEM_OP,
    S_ALL_RD,
    S_ALL_OUT
  } state_t;

  typedef struct packed {
    logic signed [31:0]  key;
    logic [7:0]          count;
    logic [IDENT_W-1:0]  ident;
  } slot_rec_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [15:0]        owner;
  } sem_rec_t;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_rd;
    logic scan_chk;
    logic make;
    logic cnt_clr;
    logic clr_wr;
    logic sem_rd;
    logic all_rd;
    logic emit;
    res_t res;
  } ctl_cmd_t;

  typedef struct packed {
    action_t act;
    logic    bad_cnt;
    logic    scan_done;
    logic    found;
    logic    free;
    logic    create;
    logic    mismatch;
    logic    idx_bad;
    logic    out_free;
    logic    clr_done;
    logic    all_last;
  } ctl_stat_t;

endpackage

[design/sse_ctrl.sv]
module sse_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sse_pkg::ctl_stat_t  stat,
  output sse_pkg::ctl_cmd_t   cmd
);

  sse_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sse_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sse_pkg::S_IDLE: begin
        if (in_valid) state_nxt = sse_pkg::S_CHECK;
      end
      sse_pkg::S_CHECK: begin
        if (stat.act == sse_pkg::ACT_GET && stat.bad_cnt) state_nxt = sse_pkg::S_ERROR;
        else state_nxt = sse_pkg::S_SCAN_RD;
      end
      sse_pkg::S_SCAN_RD:  state_nxt = sse_pkg::S_SCAN_CHK;
      sse_pkg::S_SCAN_CHK: begin
        state_nxt = stat.scan_done ? sse_pkg::S_DECIDE : sse_pkg::S_SCAN_RD;
      end
      sse_pkg::S_DECIDE: begin
        if (stat.act == sse_pkg::ACT_GET) begin
          if (stat.found) state_nxt = stat.mismatch ? sse_pkg::S_ERROR : sse_pkg::S_GET;
          else if (stat.create && stat.free) state_nxt = sse_pkg::S_CREATE;
          else state_nxt = sse_pkg::S_ERROR;
        end else if (!stat.found) begin
          state_nxt = sse_pkg::S_ERROR;
        end else begin
          case (stat.act)
            sse_pkg::ACT_REMOVE:   state_nxt = sse_pkg::S_REMOVE;
            sse_pkg::ACT_READ_ALL: state_nxt = sse_pkg::S_ALL_RD;
            sse_pkg::ACT_STAT:     state_nxt = sse_pkg::S_STAT;
            default:               state_nxt = stat.idx_bad ? sse_pkg::S_ERROR
                                                            : sse_pkg::S_SEM_RD;
          endcase
        end
      end
      sse_pkg::S_CREATE: state_nxt = sse_pkg::S_CLEAR;
      sse_pkg::S_CLEAR: begin
        if (stat.clr_done) state_nxt = sse_pkg::S_GET;
      end
      sse_pkg::S_SEM_RD: state_nxt = sse_pkg::S_SEM_OP;
      sse_pkg::S_ALL_RD: state_nxt = sse_pkg::S_ALL_OUT;
      sse_pkg::S_ALL_OUT: begin
        if (stat.out_free) state_nxt = stat.all_last ? sse_pkg::S_IDLE : sse_pkg::S_ALL_RD;
      end
      sse_pkg::S_GET, sse_pkg::S_ERROR, sse_pkg::S_REMOVE, sse_pkg::S_STAT,
      sse_pkg::S_SEM_OP: begin
        if (stat.out_free) state_nxt = sse_pkg::S_IDLE;
      end
      default: state_nxt = sse_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.res = sse_pkg::RES_ERROR;
    in_stall = (state_r != sse_pkg::S_IDLE);
    unique case (state_r)
      sse_pkg::S_IDLE:     cmd.load = in_valid;
      sse_pkg::S_CHECK:    cmd.scan_clr = 1'b1;
      sse_pkg::S_SCAN_RD:  cmd.scan_rd = 1'b1;
      sse_pkg::S_SCAN_CHK: cmd.scan_chk = 1'b1;
      sse_pkg::S_DECIDE:   cmd.cnt_clr = 1'b1;
      sse_pkg::S_CREATE:   cmd.make = 1'b1;
      sse_pkg::S_CLEAR:    cmd.clr_wr = 1'b1;
      sse_pkg::S_SEM_RD:   cmd.sem_rd = 1'b1;
      sse_pkg::S_ALL_RD:   cmd.all_rd = 1'b1;
      sse_pkg::S_GET: begin
        cmd.emit = stat.out_free;
        cmd.res  = sse_pkg::RES_GET;
      end
      sse_pkg::S_ERROR: begin
        cmd.emit = stat.out_free;
        cmd.res  = sse_pkg::RES_ERROR;
      end
      sse_pkg::S_REMOVE: begin
        cmd.emit = stat.out_free;
        cmd.res  = sse_pkg::RES_REMOVE;
      end
      sse_pkg::S_STAT: begin
        cmd.emit = stat.out_free;
        cmd.res  = sse_pkg::RES_STAT;
      end
      sse_pkg::S_SEM_OP: begin
        cmd.emit = stat.out_free;
        cmd.res  = sse_pkg::RES_OP;
      end
      sse_pkg::S_ALL_OUT: begin
        cmd.emit = stat.out_free;
        cmd.res  = sse_pkg::RES_ALL;
      end
      default: cmd.load = 1'b0;
    endcase
  end

endmodule

[design/sse_dpath.sv]
module sse_dpath #(
  parameter int NUM_SETS     = sse_pkg::NUM_SETS_DEF,
  parameter int SEMS_PER_SET = sse_pkg::SEMS_PER_SET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          in_action,
  input  logic signed [31:0]  in_set_key,
  input  logic [7:0]          in_sem_count,
  input  logic                in_create,
  input  logic [30:0]         in_set_ident,
  input  logic [7:0]          in_sem_index,
  input  logic signed [15:0]  in_delta,
  input  logic                in_nowait,
  input  logic [15:0]         in_requester,
  input  logic signed [31:0]  in_new_value,
  input  sse_pkg::ctl_cmd_t   cmd,
  output sse_pkg::ctl_stat_t  stat,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_data,
  output logic [30:0]         out_ident_out,
  output logic [7:0]          out_count_out,
  output logic                out_wake,
  output logic [7:0]          out_wake_index,
  output logic                out_last
);

  localparam int SLOT_AW   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int SEM_IW    = (SEMS_PER_SET > 1) ? $clog2(SEMS_PER_SET) : 1;
  localparam int SEM_DEPTH = NUM_SETS * SEMS_PER_SET;
  localparam int SEM_AW    = (SEM_DEPTH > 1) ? $clog2(SEM_DEPTH) : 1;
  localparam int ALL_LIM   = (SEMS_PER_SET < sse_pkg::MAX_RESULTS) ? SEMS_PER_SET
                                                                  : sse_pkg::MAX_RESULTS;

  // latched item
  sse_pkg::action_t   act_r;
  logic signed [31:0] key_r;
  logic [7:0]         cnt_r;
  logic               create_r;
  logic [30:0]        ident_r;
  logic [7:0]         idx_r;
  logic signed [15:0] delta_r;
  logic               nowait_r;
  logic [15:0]        req_r;
  logic signed [31:0] nval_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r    <= sse_pkg::action_t'(in_action);
      key_r    <= in_set_key;
      cnt_r    <= in_sem_count;
      create_r <= in_create;
      ident_r  <= in_set_ident;
      idx_r    <= in_sem_index;
      delta_r  <= in_delta;
      nowait_r <= in_nowait;
      req_r    <= in_requester;
      nval_r   <= in_new_value;
    end
  end

  // slot table
  sse_pkg::slot_rec_t slot_mem [NUM_SETS];
  sse_pkg::slot_rec_t slot_q;
  sse_pkg::slot_rec_t new_rec;
  logic [NUM_SETS-1:0] used_r;
  logic [NUM_SETS-1:0] seen_r;
  logic [SLOT_AW-1:0]  sp_r;
  logic [SLOT_AW-1:0]  free_slot_r;
  logic [SLOT_AW-1:0]  fslot_r;
  logic                found_r;
  logic                free_r;
  logic [30:0]         free_ident_r;
  logic signed [31:0]  f_key_r;
  logic [7:0]          f_cnt_r;
  logic [30:0]         f_ident_r;
  logic [30:0]         next_ident_r;
  logic [30:0]         next_ident_inc;
  logic [30:0]         new_id;
  logic                hit_now;
  logic                free_now;
  logic                take_new;

  assign hit_now  = used_r[sp_r] && ((act_r == sse_pkg::ACT_GET) ? (slot_q.key == key_r)
                                                                 : (slot_q.ident == ident_r));
  assign free_now = (act_r == sse_pkg::ACT_GET) && !used_r[sp_r] && !free_r;
  assign take_new = (free_ident_r == 31'd0);
  assign new_id   = take_new ? next_ident_r : free_ident_r;
  assign next_ident_inc = next_ident_r + 31'd1;
  assign new_rec  = '{key: key_r, count: cnt_r, ident: new_id};

  always_ff @(posedge clk) begin
    if (cmd.make) slot_mem[free_slot_r] <= new_rec;
    if (cmd.scan_rd) slot_q <= slot_mem[sp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      seen_r       <= '0;
      next_ident_r <= 31'd1;
    end else begin
      if (cmd.make) begin
        used_r[free_slot_r] <= 1'b1;
        seen_r[free_slot_r] <= 1'b1;
        if (take_new) next_ident_r <= (next_ident_inc == 31'd0) ? 31'd1 : next_ident_inc;
      end
      if (cmd.emit && cmd.res == sse_pkg::RES_REMOVE) used_r[fslot_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      sp_r    <= '0;
      found_r <= 1'b0;
      free_r  <= 1'b0;
    end
    if (cmd.scan_chk) begin
      if (hit_now) begin
        found_r   <= 1'b1;
        fslot_r   <= sp_r;
        f_key_r   <= slot_q.key;
        f_cnt_r   <= slot_q.count;
        f_ident_r <= slot_q.ident;
      end
      if (free_now) begin
        free_r       <= 1'b1;
        free_slot_r  <= sp_r;
        free_ident_r <= seen_r[sp_r] ? slot_q.ident : 31'd0;
      end
      if (sp_r != SLOT_AW'(NUM_SETS - 1)) sp_r <= sp_r + SLOT_AW'(1);
    end
    if (cmd.make) begin
      fslot_r   <= free_slot_r;
      f_key_r   <= key_r;
      f_cnt_r   <= cnt_r;
      f_ident_r <= new_id;
    end
  end

  // semaphore store
  sse_pkg::sem_rec_t sem_mem [SEM_DEPTH];
  sse_pkg::sem_rec_t sem_q;
  sse_pkg::sem_rec_t sem_wd;
  logic [SEM_AW-1:0] base;
  logic [SEM_AW-1:0] addr_idx;
  logic [SEM_AW-1:0] addr_j;
  logic [SEM_AW-1:0] sem_wa;
  logic [SEM_AW-1:0] sem_ra;
  logic              sem_we;
  logic [7:0]        j_r;

  assign base     = SEM_AW'(fslot_r) * SEM_AW'(SEMS_PER_SET);
  assign addr_idx = base + SEM_AW'(idx_r[SEM_IW-1:0]);
  assign addr_j   = base + SEM_AW'(j_r[SEM_IW-1:0]);
  assign sem_ra   = cmd.sem_rd ? addr_idx : addr_j;

  // operation on the fetched semaphore
  logic signed [31:0] v;
  logic signed [32:0] sum;
  logic signed [31:0] op_wval;
  logic               op_write;
  logic               op_wake;
  logic [1:0]         op_status;
  logic signed [31:0] op_data;

  assign v   = sem_q.value;
  assign sum = $signed({v[31], v}) + $signed({{17{delta_r[15]}}, delta_r});

  always_comb begin
    op_status = sse_pkg::ST_OK;
    op_data   = '0;
    op_wake   = 1'b0;
    op_write  = 1'b0;
    op_wval   = sum[31:0];
    case (act_r)
      sse_pkg::ACT_OPERATE: begin
        if (delta_r > 16'sd0) begin
          op_write = 1'b1;
          op_wval  = (sum > 33'sd2147483647) ? 32'sh7FFFFFFF : sum[31:0];
          op_wake  = (v <= 32'sd0) && (op_wval > 32'sd0);
        end else if ((delta_r < 16'sd0 && sum >= 33'sd0) ||
                     (delta_r == 16'sd0 && v == 32'sd0)) begin
          op_write = 1'b1;
        end else begin
          op_status = nowait_r ? sse_pkg::ST_ERROR : sse_pkg::ST_BLOCKED;
        end
      end
      sse_pkg::ACT_WRITE_VAL: begin
        op_write = 1'b1;
        op_wval  = nval_r;
        op_wake  = nval_r > v;
      end
      sse_pkg::ACT_READ_VAL:   op_data = v;
      sse_pkg::ACT_READ_OWNER: op_data = $signed({16'd0, sem_q.owner});
      default:                 op_data = '0;
    endcase
  end

  assign sem_we = cmd.clr_wr || (cmd.emit && cmd.res == sse_pkg::RES_OP && op_write);
  assign sem_wa = cmd.clr_wr ? addr_j : addr_idx;
  assign sem_wd = cmd.clr_wr ? '{value: 32'sd0, owner: 16'd0}
                             : '{value: op_wval, owner: req_r};

  always_ff @(posedge clk) begin
    if (sem_we) sem_mem[sem_wa] <= sem_wd;
    if (cmd.sem_rd || cmd.all_rd) sem_q <= sem_mem[sem_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.cnt_clr || cmd.make) j_r <= 8'd0;
    else if (cmd.clr_wr || (cmd.emit && cmd.res == sse_pkg::RES_ALL)) j_r <= j_r + 8'd1;
  end

  logic [7:0] all_n;
  assign all_n = (f_cnt_r < 8'(ALL_LIM)) ? f_cnt_r : 8'(ALL_LIM);

  // result register
  logic               out_valid_r;
  logic [1:0]         status_r;
  logic signed [31:0] data_r;
  logic [30:0]        ident_out_r;
  logic [7:0]         count_r;
  logic               wake_r;
  logic [7:0]         widx_r;
  logic               last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status_r    <= sse_pkg::ST_OK;
      data_r      <= '0;
      ident_out_r <= '0;
      count_r     <= '0;
      wake_r      <= 1'b0;
      widx_r      <= '0;
      last_r      <= 1'b0;
      case (cmd.res)
        sse_pkg::RES_ERROR: status_r <= sse_pkg::ST_ERROR;
        sse_pkg::RES_GET:   ident_out_r <= f_ident_r;
        sse_pkg::RES_STAT: begin
          data_r      <= f_key_r;
          ident_out_r <= f_ident_r;
          count_r     <= f_cnt_r;
        end
        sse_pkg::RES_OP: begin
          status_r <= op_status;
          data_r   <= op_data;
          wake_r   <= op_wake;
          widx_r   <= op_wake ? idx_r : 8'd0;
        end
        sse_pkg::RES_ALL: begin
          data_r <= v;
          last_r <= (j_r == all_n - 8'd1);
        end
        default: status_r <= sse_pkg::ST_OK;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_data       = data_r;
  assign out_ident_out  = ident_out_r;
  assign out_count_out  = count_r;
  assign out_wake       = wake_r;
  assign out_wake_index = widx_r;
  assign out_last       = last_r;

  // status toward the controller
  assign stat.act       = act_r;
  assign stat.bad_cnt   = (cnt_r == 8'd0) || (cnt_r > 8'(SEMS_PER_SET));
  assign stat.scan_done = hit_now || (sp_r == SLOT_AW'(NUM_SETS - 1));
  assign stat.found     = found_r;
  assign stat.free      = free_r;
  assign stat.create    = create_r;
  assign stat.mismatch  = (f_cnt_r != cnt_r);
  assign stat.idx_bad   = (idx_r >= f_cnt_r) || (idx_r >= 8'(SEMS_PER_SET));
  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.clr_done  = (j_r == f_cnt_r - 8'd1);
  assign stat.all_last  = (j_r == all_n - 8'd1);

endmodule

[design/semaphore_set_engine.sv]
// semaphore set engine: a table of counting semaphore sets
//
// input channel: one beat per request (get/create, operate, remove, read
// value, write value, read owner, read all, stat), moved on in_valid with
// in_stall low. result channel: out_valid/out_stall, one beat per request,
// or, for read all, one beat per semaphore up to MAX_RESULTS with out_last
// on the final one. the engine works on one request at a time; in_stall
// stays high from the accepted beat until its final result sits in the
// output register. a check step clears the scan, then each slot of the set
// table is read and checked by key or identifier until a hit or the last
// slot; a decide step then picks a get, remove, stat or error result, a
// semaphore access, a read-all beat, or a create that writes the slot and
// zeroes its count entries; a get with a bad count errors from the check.
// the next request is taken the cycle after its final result loads. a
// result held under out_stall keeps its payload; the engine waits on it
// before loading another result and takes the next request meanwhile.
// reset clears the slot valid bits and restarts identifiers at 1; the
// semaphore store needs no clearing pass, a create zeroes its entries.
module semaphore_set_engine #(
  parameter int NUM_SETS     = sse_pkg::NUM_SETS_DEF,
  parameter int SEMS_PER_SET = sse_pkg::SEMS_PER_SET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_action,
  input  logic signed [31:0]  in_set_key,
  input  logic [7:0]          in_sem_count,
  input  logic                in_create,
  input  logic [30:0]         in_set_ident,
  input  logic [7:0]          in_sem_index,
  input  logic signed [15:0]  in_delta,
  input  logic                in_nowait,
  input  logic [15:0]         in_requester,
  input  logic signed [31:0]  in_new_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic signed [31:0]  out_data,
  output logic [30:0]         out_ident_out,
  output logic [7:0]          out_count_out,
  output logic                out_wake,
  output logic [7:0]          out_wake_index,
  output logic                out_last
);

  // command and status between sequencer and datapath
  sse_pkg::ctl_cmd_t  cmd;
  sse_pkg::ctl_stat_t stat;

  sse_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // tables, item register, semaphore arithmetic and result register
  sse_dpath #(
    .NUM_SETS     (NUM_SETS),
    .SEMS_PER_SET (SEMS_PER_SET)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_action      (in_action),
    .in_set_key     (in_set_key),
    .in_sem_count   (in_sem_count),
    .in_create      (in_create),
    .in_set_ident   (in_set_ident),
    .in_sem_index   (in_sem_index),
    .in_delta       (in_delta),
    .in_nowait      (in_nowait),
    .in_requester   (in_requester),
    .in_new_value   (in_new_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_data       (out_data),
    .out_ident_out  (out_ident_out),
    .out_count_out  (out_count_out),
    .out_wake       (out_wake),
    .out_wake_index (out_wake_index),
    .out_last       (out_last)
  );

endmodule

[design/sse_checker.sv]
module sse_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic signed [31:0] out_data,
  input logic [30:0]        out_ident_out,
  input logic [7:0]         out_count_out,
  input logic               out_wake,
  input logic [7:0]         out_wake_index,
  input logic               out_last
);

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_data) &&
      $stable(out_last) && $stable(out_wake))
    else $error("stalled result changed");

  // error and blocked beats carry nothing else
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sse_pkg::ST_OK |-> out_data == 32'sd0 &&
      out_ident_out == 31'd0 && out_count_out == 8'd0 && !out_wake && !out_last)
    else $error("failing result with payload");

  // wake comes only on a plain ok beat
  a_wake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wake |-> out_status == sse_pkg::ST_OK && out_data == 32'sd0 && !out_last)
    else $error("wake on wrong beat");

  a_widx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_wake |-> out_wake_index == 8'd0)
    else $error("wake index without wake");

endmodule

bind semaphore_set_engine sse_checker u_sse_checker (.*);
